/* rtl/buddy_block_allocator_defines.svh */
// Assertion macros shared by the buddy block allocator modules.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BBA_ASSERT_IMPL(label, ante, cons, msg)
`define BBA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/bba_pkg.sv */
// Shared types and constants of the buddy block allocator.
package bba_pkg;

  localparam int SIZE_W      = 14;
  localparam int ADDR_W      = 32;
  localparam int ORD_W       = 4;
  localparam int KORD_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int ORDER_LIMIT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORD_CAP    = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_BIG     = 3'd2,
    ST_NOFREE  = 3'd3,
    ST_BADFREE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_DIV,
    DP_WALK_RD,
    DP_WALK_EV,
    DP_PICK,
    DP_SPLIT,
    DP_GRANT,
    DP_FREE_RD,
    DP_FREE_CLR,
    DP_MERGE_RD,
    DP_MERGE_EV,
    DP_FREE_END,
    DP_ERROR
  } dp_op_e;

  typedef struct packed {
    logic             free;
    logic             alloc;
    logic [ORD_W-1:0] order;
  } entry_t;

  typedef struct packed {
    dp_op_e  op;
    status_e err;
  } dp_cmd_t;

  typedef struct packed {
    logic init_req;
    logic clr_last;
    logic is_free;
    logic zero_req;
    logic too_big;
    logic bad_pre;
    logic entry_alloc;
    logic merge_more;
    logic merge_ok;
    logic walk_stop;
    logic best_found;
    logic split_more;
  } dp_stat_t;

endpackage

/* rtl/bba_store.sv */
// Block descriptor memory: one write port, one registered read port.
module bba_store import bba_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/bba_datapath.sv */
// Datapath: configuration, counters, descriptor store, address and order arithmetic.
`include "buddy_block_allocator_defines.svh"
module bba_datapath import bba_pkg::*; #(
  parameter int TOP_ORDER    = 10,
  parameter int UNIT_BYTES   = 8,
  parameter int HEADER_BYTES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_cmd_i,
  input  logic [SIZE_W-1:0]    in_req_size_i,
  input  logic [ADDR_W-1:0]    in_free_address_i,
  output logic [2:0]           res_status_o,
  output logic [ADDR_W-1:0]    res_address_o,
  output logic [ORD_W-1:0]     res_order_o,
  output logic [SIZE_W-1:0]    res_used_o,
  output logic [SIZE_W-1:0]    res_peak_o
);

  localparam int IDX_W = TOP_ORDER;
  localparam int unsigned UNIT_COUNT = 1 << TOP_ORDER;
  localparam int REM_W = $clog2(UNIT_BYTES) + 1;
  localparam int DIV_SH = SIZE_W + 7;
  localparam int DIV_MUL = ((1 << DIV_SH) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam logic [ORD_W-1:0] RST_MAX = (TOP_ORDER > 15) ? 4'd15 : ORD_W'(TOP_ORDER);
  localparam logic RST_INIT_FREE = ((UNIT_BYTES << TOP_ORDER) <= 8192);

  function automatic logic [31:0] blk_bytes(input logic [KORD_W-1:0] ord);
    blk_bytes = 32'(UNIT_BYTES) << ord;
  endfunction

  logic [ADDR_W-1:0] heap_base_q;
  logic [SIZE_W-1:0] heap_bytes_q;
  logic [ORD_W-1:0]  ord_cap_q;
  logic              init_free_q;
  logic [IDX_W-1:0]  clr_ptr_q;
  logic [SIZE_W-1:0] used_q, peak_q;

  logic              cmd_q, req_zero_q;
  logic [KORD_W-1:0] k_q;
  logic [ADDR_W-1:0] off_q;
  logic [SIZE_W-1:0] quot_q;
  logic [REM_W-1:0]  rem_q;
  logic [IDX_W:0]    walk_ptr_q;
  logic [IDX_W-1:0]  best_u_q, u_q;
  logic [ORD_W-1:0]  best_o_q, cur_q;
  logic              best_vld_q;
  status_e           res_status_q;
  logic [ADDR_W-1:0] res_address_q;
  logic [ORD_W-1:0]  res_order_q;
  logic [SIZE_W-1:0] res_used_q, res_peak_q;

  entry_t            rd_entry, wr_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  logic [31:0]       need;
  logic [KORD_W-1:0] k_new;
  logic [ADDR_W-1:0] off_new;
  logic [47:0]       div_prod;
  logic [SIZE_W-1:0] div_quot, div_back;
  logic [REM_W-1:0]  rem_d;
  logic [31:0]       u_free, walk_next, split_bu, merge_bu;
  logic [ORD_W-1:0]  cur_m1, max_sat;
  logic              take_best, split_fit, merge_fit, merge_ok;
  logic [SIZE_W-1:0] used_new, peak_new;
  logic              init_req;

  assign cfg_ready_o = 1'b1;
  assign init_req    = cfg_valid_i && (cfg_index_i == REG_ORD_CAP);
  assign max_sat     = (32'(cfg_data_i[3:0]) > 32'(TOP_ORDER)) ? RST_MAX : cfg_data_i[3:0];

  // smallest order whose block holds request plus header
  assign need = 32'(in_req_size_i) + 32'(HEADER_BYTES);
  always_comb begin
    k_new = KORD_W'(ORDER_LIMIT);
    for (int i = ORDER_LIMIT; i >= 0; i--) begin
      if (blk_bytes(KORD_W'(i)) >= need) k_new = KORD_W'(i);
    end
  end

  assign off_new = in_free_address_i - heap_base_q - 32'(HEADER_BYTES);

  // divide the offset by the unit size with a reciprocal multiply
  assign div_prod = 48'(off_q[SIZE_W-1:0]) * 48'(DIV_MUL);
  assign div_quot = div_prod[DIV_SH +: SIZE_W];
  assign div_back = SIZE_W'(32'(div_quot) * 32'(UNIT_BYTES));
  assign rem_d    = REM_W'(off_q[SIZE_W-1:0] - div_back);
  assign u_free   = 32'(quot_q);

  assign walk_next = 32'(walk_ptr_q) + (32'd1 << rd_entry.order);
  assign take_best = rd_entry.free && ({1'b0, rd_entry.order} >= k_q)
                     && (!best_vld_q || (rd_entry.order < best_o_q));

  assign cur_m1    = cur_q - 4'd1;
  assign split_bu  = 32'(u_q) + (32'd1 << cur_m1);
  assign split_fit = (split_bu < UNIT_COUNT)
                     && (split_bu * 32'(UNIT_BYTES) + blk_bytes({1'b0, cur_m1})
                         <= 32'(heap_bytes_q));

  assign merge_bu  = 32'(u_q) ^ (32'd1 << k_q);
  assign merge_fit = (merge_bu < UNIT_COUNT)
                     && (merge_bu * 32'(UNIT_BYTES) + blk_bytes(k_q) <= 32'(heap_bytes_q));
  assign merge_ok  = merge_fit && rd_entry.free && ({1'b0, rd_entry.order} == k_q);

  assign used_new = used_q + SIZE_W'(blk_bytes({1'b0, cur_q}));
  assign peak_new = (used_new > peak_q) ? used_new : peak_q;

  always_comb begin
    stat_o.init_req    = init_req;
    stat_o.clr_last    = (clr_ptr_q == '1);
    stat_o.is_free     = cmd_q;
    stat_o.zero_req    = req_zero_q;
    stat_o.too_big     = k_q > {1'b0, ord_cap_q};
    stat_o.bad_pre     = (off_q >= 32'(heap_bytes_q)) || (rem_q != '0)
                         || (u_free >= UNIT_COUNT);
    stat_o.entry_alloc = rd_entry.alloc;
    stat_o.merge_more  = k_q < {1'b0, ord_cap_q};
    stat_o.merge_ok    = merge_ok;
    stat_o.walk_stop   = (!rd_entry.free && !rd_entry.alloc) || (walk_next >= UNIT_COUNT)
                         || (rd_entry.free && ({1'b0, rd_entry.order} == k_q));
    stat_o.best_found  = best_vld_q;
    stat_o.split_more  = (cur_q > k_q[ORD_W-1:0]) && (k_q[ORD_W] == 1'b0) && split_fit;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_ptr_q;
    wr_data = '0;
    rd_addr = walk_ptr_q[IDX_W-1:0];
    unique case (cmd_i.op)
      DP_CLEAR: begin
        wr_en = 1'b1;
        if (clr_ptr_q == '0) begin
          wr_data = '{free: init_free_q, alloc: 1'b0, order: ord_cap_q};
        end
      end
      DP_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(split_bu);
        wr_data = '{free: 1'b1, alloc: 1'b0, order: cur_m1};
      end
      DP_GRANT: begin
        wr_en   = 1'b1;
        wr_addr = u_q;
        wr_data = '{free: 1'b0, alloc: 1'b1, order: cur_q};
      end
      DP_FREE_RD: rd_addr = IDX_W'(quot_q);
      DP_FREE_CLR: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(quot_q);
        wr_data = '{free: 1'b0, alloc: 1'b0, order: rd_entry.order};
      end
      DP_MERGE_RD: rd_addr = IDX_W'(merge_bu);
      DP_MERGE_EV: begin
        wr_en   = merge_ok;
        wr_addr = IDX_W'(merge_bu);
        wr_data = '{free: 1'b0, alloc: rd_entry.alloc, order: rd_entry.order};
      end
      DP_FREE_END: begin
        wr_en   = 1'b1;
        wr_addr = u_q;
        wr_data = '{free: 1'b1, alloc: 1'b0, order: k_q[ORD_W-1:0]};
      end
      default: ;
    endcase
  end

  bba_store #(
    .DEPTH (UNIT_COUNT),
    .AW    (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_bytes_q <= 14'd8192;
      ord_cap_q    <= RST_MAX;
      init_free_q  <= RST_INIT_FREE;
      clr_ptr_q    <= '0;
      used_q       <= '0;
      peak_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_HEAP_BASE:  heap_base_q  <= cfg_data_i;
          REG_HEAP_BYTES: heap_bytes_q <= cfg_data_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (init_req) begin
        ord_cap_q   <= max_sat;
        init_free_q <= blk_bytes({1'b0, max_sat}) <= 32'(heap_bytes_q);
        clr_ptr_q   <= '0;
        used_q      <= '0;
        peak_q      <= '0;
      end else begin
        unique case (cmd_i.op)
          DP_CLEAR: clr_ptr_q <= clr_ptr_q + 1'b1;
          DP_GRANT: begin
            used_q <= used_new;
            peak_q <= peak_new;
          end
          DP_FREE_CLR: used_q <= used_q - SIZE_W'(blk_bytes({1'b0, rd_entry.order}));
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        cmd_q      <= in_cmd_i;
        req_zero_q <= (in_req_size_i == '0);
        k_q        <= k_new;
        off_q      <= off_new;
        walk_ptr_q <= '0;
        best_vld_q <= 1'b0;
      end
      DP_DIV: begin
        rem_q  <= rem_d;
        quot_q <= div_quot;
      end
      DP_WALK_EV: begin
        if (take_best) begin
          best_u_q   <= walk_ptr_q[IDX_W-1:0];
          best_o_q   <= rd_entry.order;
          best_vld_q <= 1'b1;
        end
        walk_ptr_q <= (IDX_W+1)'(walk_next);
      end
      DP_PICK: begin
        cur_q <= best_o_q;
        u_q   <= best_u_q;
      end
      DP_SPLIT: cur_q <= cur_m1;
      DP_GRANT: begin
        res_status_q  <= ST_OK;
        res_address_q <= heap_base_q + 32'(u_q) * 32'(UNIT_BYTES) + 32'(HEADER_BYTES);
        res_order_q   <= cur_q;
        res_used_q    <= used_new;
        res_peak_q    <= peak_new;
      end
      DP_FREE_CLR: begin
        k_q <= {1'b0, rd_entry.order};
        u_q <= IDX_W'(quot_q);
      end
      DP_MERGE_EV: begin
        if (merge_ok) begin
          k_q <= k_q + 1'b1;
          if (IDX_W'(merge_bu) < u_q) u_q <= IDX_W'(merge_bu);
        end
      end
      DP_FREE_END: begin
        res_status_q  <= ST_OK;
        res_address_q <= '0;
        res_order_q   <= k_q[ORD_W-1:0];
        res_used_q    <= used_q;
        res_peak_q    <= peak_q;
      end
      DP_ERROR: begin
        res_status_q  <= cmd_i.err;
        res_address_q <= '0;
        res_order_q   <= '0;
        res_used_q    <= used_q;
        res_peak_q    <= peak_q;
      end
      default: ;
    endcase
  end

  assign res_status_o  = res_status_q;
  assign res_address_o = res_address_q;
  assign res_order_o   = res_order_q;
  assign res_used_o    = res_used_q;
  assign res_peak_o    = res_peak_q;

  `BBA_ASSERT_IMPL(a_walk_in_store, cmd_i.op == DP_WALK_RD, 32'(walk_ptr_q) < UNIT_COUNT, "walk left the store")
  `BBA_ASSERT_IMPL(a_split_above_req, cmd_i.op == DP_SPLIT, {1'b0, cur_q} > k_q, "split below requested order")
  `BBA_ASSERT_IMPL(a_merge_below_cap, cmd_i.op == DP_MERGE_EV, k_q < {1'b0, ord_cap_q}, "merge past largest order")

endmodule

/* rtl/bba_ctrl.sv */
// Controller: sequences clearing, search, split, division and merge steps.
`include "buddy_block_allocator_defines.svh"
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_DIV, S_FCHK, S_FREE_RD, S_FREE_EV,
    S_MERGE_TEST, S_MERGE_RD, S_MERGE_EV, S_FREE_END, S_WALK_RD, S_WALK_EV,
    S_WALK_END, S_SPLIT, S_GRANT, S_ERROR
  } state_e;

  state_e  state_q, state_d;
  status_e err_q, err_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free, res_op;
  dp_op_e  op;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    op      = DP_NOP;
    unique case (state_q)
      S_CLEAR: begin
        op = DP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && !stat_i.init_req) begin
          op      = DP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat_i.is_free) begin
          state_d = S_DIV;
        end else if (stat_i.zero_req) begin
          err_d   = ST_ZERO;
          state_d = S_ERROR;
        end else if (stat_i.too_big) begin
          err_d   = ST_BIG;
          state_d = S_ERROR;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_DIV: begin
        op      = DP_DIV;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (stat_i.bad_pre) begin
          err_d   = ST_BADFREE;
          state_d = S_ERROR;
        end else begin
          state_d = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        op      = DP_FREE_RD;
        state_d = S_FREE_EV;
      end
      S_FREE_EV: begin
        if (!stat_i.entry_alloc) begin
          err_d   = ST_BADFREE;
          state_d = S_ERROR;
        end else begin
          op      = DP_FREE_CLR;
          state_d = S_MERGE_TEST;
        end
      end
      S_MERGE_TEST: state_d = stat_i.merge_more ? S_MERGE_RD : S_FREE_END;
      S_MERGE_RD: begin
        op      = DP_MERGE_RD;
        state_d = S_MERGE_EV;
      end
      S_MERGE_EV: begin
        op      = DP_MERGE_EV;
        state_d = stat_i.merge_ok ? S_MERGE_TEST : S_FREE_END;
      end
      S_FREE_END: begin
        if (out_free) begin
          op      = DP_FREE_END;
          state_d = S_IDLE;
        end
      end
      S_WALK_RD: begin
        op      = DP_WALK_RD;
        state_d = S_WALK_EV;
      end
      S_WALK_EV: begin
        op      = DP_WALK_EV;
        state_d = stat_i.walk_stop ? S_WALK_END : S_WALK_RD;
      end
      S_WALK_END: begin
        if (stat_i.best_found) begin
          op      = DP_PICK;
          state_d = S_SPLIT;
        end else begin
          err_d   = ST_NOFREE;
          state_d = S_ERROR;
        end
      end
      S_SPLIT: begin
        if (stat_i.split_more) op = DP_SPLIT;
        else                   state_d = S_GRANT;
      end
      S_GRANT: begin
        if (out_free) begin
          op      = DP_GRANT;
          state_d = S_IDLE;
        end
      end
      S_ERROR: begin
        if (out_free) begin
          op      = DP_ERROR;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // a largest-order write restarts the clearing pass
    if (stat_i.init_req) state_d = S_CLEAR;
  end

  assign res_op = (op == DP_GRANT) || (op == DP_FREE_END) || (op == DP_ERROR);

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) out_valid_d = 1'b0;
    if (res_op)       out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.op    = op;
  assign cmd_o.err   = err_q;
  assign in_stall_o  = (state_q != S_IDLE) || stat_i.init_req;
  assign out_valid_o = out_valid_q;

  `BBA_ASSERT_IMPL(a_result_slot, res_op, !out_valid_q || !out_stall_i, "result overwrote a pending transfer")
  `BBA_ASSERT_NEXT(a_init_clears, stat_i.init_req, state_q == S_CLEAR, "largest-order write did not start clearing")
  `BBA_ASSERT_NEXT(a_hold_result, out_valid_q && out_stall_i, out_valid_q, "pending result dropped")

endmodule

/* rtl/buddy_block_allocator.sv */
// Binary buddy allocator: one result per request, one request in flight.
// Allocate: the blocks are walked in address order for the best fit, then split down to the requested order.
// Free: the offset is divided by the unit size and checked, then merged with each free buddy in turn.
// A new request is taken while the previous result still waits for its transfer.
// Reset and every largest-order write run a clearing pass over
// the descriptor store, during which no request is taken; configuration is always taken.
module buddy_block_allocator import bba_pkg::*; #(
  parameter int TOP_ORDER    = 10,
  parameter int UNIT_BYTES   = 8,
  parameter int HEADER_BYTES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [SIZE_W-1:0]    req_size_i,
  input  logic [ADDR_W-1:0]    free_address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [ADDR_W-1:0]    granted_address_o,
  output logic [ORD_W-1:0]     granted_order_o,
  output logic [SIZE_W-1:0]    used_bytes_o,
  output logic [SIZE_W-1:0]    peak_bytes_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  bba_datapath #(
    .TOP_ORDER    (TOP_ORDER),
    .UNIT_BYTES   (UNIT_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_cmd_i          (cmd_i),
    .in_req_size_i     (req_size_i),
    .in_free_address_i (free_address_i),
    .res_status_o      (status_o),
    .res_address_o     (granted_address_o),
    .res_order_o       (granted_order_o),
    .res_used_o        (used_bytes_o),
    .res_peak_o        (peak_bytes_o)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the buddy block allocator: directed, config, pressure and random tests.
module testbench import bba_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS = 1024;
  localparam int UNIT_SZ = 8;
  localparam int HDR_SZ = 8;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic [ORD_W-1:0]  order;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] peak;
  } grant_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 cmd_i = 1'b0;
  logic [SIZE_W-1:0]    req_size_i = '0;
  logic [ADDR_W-1:0]    free_address_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [2:0]           status_o;
  logic [ADDR_W-1:0]    granted_address_o;
  logic [ORD_W-1:0]     granted_order_o;
  logic [SIZE_W-1:0]    used_bytes_o;
  logic [SIZE_W-1:0]    peak_bytes_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ADDR_W-1:0]    cfg_data_i = '0;

  buddy_block_allocator u_dut (.*);

  // allocator mirror
  bit                 free_mark [UNITS];
  bit                 alloc_mark[UNITS];
  int unsigned        blk_order [UNITS];
  int unsigned        heap_base, heap_bytes, max_ord, in_use, peak_use;
  int                 live_units[$];
  grant_t             pending_q[$];
  int                 errors = 0;
  int                 burst_left = 0;
  bit                 no_gaps = 1'b0;
  int                 hold_left = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned blk_bytes(int unsigned k);
    return UNIT_SZ << k;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < UNITS; i++) begin
      free_mark[i] = 0;
      alloc_mark[i] = 0;
      blk_order[i] = 0;
    end
    blk_order[0] = max_ord;
    if (blk_bytes(max_ord) <= heap_bytes) free_mark[0] = 1;
    in_use = 0;
    peak_use = 0;
    live_units.delete();
  endfunction

  function automatic grant_t model_op(bit cmd, int unsigned req, int unsigned faddr);
    grant_t r;
    int unsigned need, k, cur, found, off, u, bu, half;
    bit hit;
    r = '0;
    r.status = ST_OK;
    hit = 0;
    found = 0;
    if (!cmd) begin
      if (req == 0) r.status = ST_ZERO;
      else begin
        need = ((req + HDR_SZ + UNIT_SZ - 1) / UNIT_SZ) * UNIT_SZ;
        k = 0;
        while (blk_bytes(k) < need && k < ORDER_LIMIT) k++;
        if (k > max_ord) r.status = ST_BIG;
        else begin
          for (cur = k; cur <= max_ord; cur++) begin
            for (u = 0; u < UNITS; u++)
              if (free_mark[u] && blk_order[u] == cur) begin
                found = u;
                hit = 1;
                break;
              end
            if (hit) break;
          end
          if (!hit) r.status = ST_NOFREE;
          else begin
            free_mark[found] = 0;
            while (cur > k) begin
              half = 1 << (cur - 1);
              bu = found + half;
              if (bu * UNIT_SZ + blk_bytes(cur - 1) > heap_bytes || bu >= UNITS) break;
              free_mark[bu] = 1;
              alloc_mark[bu] = 0;
              blk_order[bu] = cur - 1;
              cur--;
            end
            alloc_mark[found] = 1;
            blk_order[found] = cur;
            in_use = (in_use + blk_bytes(cur)) & 14'h3fff;
            if (in_use > peak_use) peak_use = in_use;
            live_units.push_back(found);
            r.addr = heap_base + found * UNIT_SZ + HDR_SZ;
            r.order = cur;
          end
        end
      end
    end else begin
      off = faddr - heap_base - HDR_SZ;
      u = off / UNIT_SZ;
      if (off >= heap_bytes || off % UNIT_SZ != 0 || u >= UNITS || !alloc_mark[u])
        r.status = ST_BADFREE;
      else begin
        foreach (live_units[i]) if (live_units[i] == u) begin
          live_units.delete(i);
          break;
        end
        k = blk_order[u];
        alloc_mark[u] = 0;
        in_use = (in_use - blk_bytes(k)) & 14'h3fff;
        while (k < max_ord) begin
          bu = u ^ (1 << k);
          if (bu >= UNITS) break;
          if (bu * UNIT_SZ + blk_bytes(k) > heap_bytes) break;
          if (!free_mark[bu] || blk_order[bu] != k) break;
          free_mark[bu] = 0;
          if (bu < u) u = bu;
          k++;
        end
        free_mark[u] = 1;
        blk_order[u] = k;
        r.order = k;
      end
    end
    r.used = in_use;
    r.peak = peak_use;
    return r;
  endfunction

  // one request transfer; the expectation is queued at acceptance
  task automatic send_item(bit cmd, int unsigned req, int unsigned faddr);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    req_size_i <= req[SIZE_W-1:0];
    free_address_i <= faddr;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(model_op(cmd, req[SIZE_W-1:0], faddr));
    if (!no_gaps) begin
      if (burst_left > 0) burst_left--;
      else begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 4))
          @(posedge clk_i);
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(0, 8);
      end
    end
  endtask

  task automatic alloc_req(int unsigned req);
    send_item(1'b0, req, $urandom);
  endtask

  task automatic free_req(int unsigned faddr);
    send_item(1'b1, $urandom, faddr);
  endtask

  function automatic int unsigned unit_addr(int unsigned u);
    return heap_base + u * UNIT_SZ + HDR_SZ;
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HEAP_BASE: heap_base = value;
      REG_HEAP_BYTES: heap_bytes = value & 14'h3fff;
      REG_ORD_CAP: begin
        max_ord = (value & 4'hf) > 10 ? 10 : (value & 4'hf);
        clear_store();
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin
    grant_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_e'(status_o), granted_address_o, granted_order_o,
              used_bytes_o, peak_bytes_o};
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $realtime, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
          errors++;
        end
        if (got.addr !== want.addr) begin
          $display("%0t: address exp %h got %h", $realtime, want.addr, got.addr);
          errors++;
        end
        if (got.order !== want.order) begin
          $display("%0t: order exp %0d got %0d", $realtime, want.order, got.order);
          errors++;
        end
        if (got.used !== want.used) begin
          $display("%0t: used exp %0d got %0d", $realtime, want.used, got.used);
          errors++;
        end
        if (got.peak !== want.peak) begin
          $display("%0t: peak exp %0d got %0d", $realtime, want.peak, got.peak);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: a randomly picked mode, hold overrides
  always @(posedge clk_i) begin
    int unsigned cnt, mode;
    cnt++;
    if (cnt % 64 == 0) mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else case (mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic test_directed();
    alloc_req(0);
    alloc_req(8192);
    alloc_req(16383);
    alloc_req(8184);
    alloc_req(1);
    free_req(unit_addr(0));
    free_req(unit_addr(0));
    free_req(unit_addr(0) + 4);
    free_req(unit_addr(1024));
    free_req(0);
    free_req(32'hffff_ffff);
    repeat (4) alloc_req(1);
    alloc_req(100);
    alloc_req(3000);
    while (live_units.size() != 0) free_req(unit_addr(live_units[0]));
  endtask

  task automatic test_config();
    write_reg(REG_HEAP_BASE, 32'hffff_fff0);
    alloc_req(1);
    alloc_req(9);
    free_req(unit_addr(live_units[0]));
    write_reg(REG_HEAP_BYTES, 256);
    write_reg(REG_ORD_CAP, 10);
    alloc_req(1);
    write_reg(REG_HEAP_BYTES, 8192);
    write_reg(REG_ORD_CAP, 15);
    alloc_req(8184);
    write_reg(REG_ORD_CAP, 0);
    alloc_req(1);
    write_reg(REG_ORD_CAP, 10);
    write_reg(REG_HEAP_BYTES, 3000);
    alloc_req(1);
    alloc_req(1000);
    alloc_req(2000);
    while (live_units.size() != 0) free_req(unit_addr(live_units[0]));
    write_reg(REG_HEAP_BYTES, 16383);
    write_reg(REG_HEAP_BASE, 0);
    alloc_req(4000);
    free_req(unit_addr(live_units[0]));
  endtask

  task automatic random_items(int n);
    int pick, idx;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 || (pick < 90 && live_units.size() == 0))
        alloc_req($urandom_range(0, 5) == 0 ? $urandom_range(1, 8192) : $urandom_range(1, 200));
      else if (pick < 90) begin
        idx = $urandom_range(0, live_units.size() - 1);
        free_req(unit_addr(live_units[idx]));
      end else case ($urandom_range(0, 3))
        0: free_req($urandom);
        1: free_req(unit_addr($urandom_range(0, 1023)));
        2: alloc_req($urandom_range(0, 16383));
        default: free_req(unit_addr($urandom_range(0, 1023)) + $urandom_range(1, 7));
      endcase
    end
  endtask

  task automatic test_random();
    write_reg(REG_HEAP_BASE, $urandom);
    write_reg(REG_HEAP_BYTES, 8192);
    write_reg(REG_ORD_CAP, 10);
    random_items(350);
    write_reg(REG_HEAP_BYTES, $urandom_range(256, 8192));
    write_reg(REG_ORD_CAP, $urandom_range(4, 10));
    random_items(330);
    write_reg(REG_ORD_CAP, 3);
    random_items(300);
    write_reg(REG_HEAP_BYTES, 8192);
    write_reg(REG_ORD_CAP, 10);
    write_reg(REG_HEAP_BYTES, $urandom_range(3000, 7000));
    random_items(330);
    write_reg(REG_HEAP_BASE, 32'hffff_ffff);
    write_reg(REG_HEAP_BYTES, 8192);
    write_reg(REG_ORD_CAP, 9);
    random_items(300);
  endtask

  task automatic test_pressure();
    wait_idle();
    @(posedge clk_i);
    hold_left = 400;
    no_gaps = 1'b1;
    random_items(30);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    heap_base = 0;
    heap_bytes = 8192;
    max_ord = 10;
    clear_store();
    test_directed();
    test_config();
    test_pressure();
    test_random();
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #150_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
